### rtl/b64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } b64_mode_e;

  // Register index of the mode register on the configuration port.
  localparam logic REG_MODE = 1'b0;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_D0    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_D9    = 8'h39;  // '9'

  localparam int GROUP_MAX = 4;
  localparam int NUM_W     = $clog2(GROUP_MAX + 1);
  localparam int IDX_W     = $clog2(GROUP_MAX);

  typedef struct packed {
    logic [7:0] value;
    logic       has_value;
    logic       eos;
  } b64_result_t;

  // All results that one item causes, in delivery order from index 0.
  typedef struct packed {
    b64_result_t [GROUP_MAX-1:0] res;
    logic [NUM_W-1:0]            num;
  } b64_group_t;

  // Maps a six-bit value onto its alphabet character.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] c;
    c = {2'b00, s};
    if (s < 6'd26) begin
      c = CHAR_UA + {2'b00, s};
    end else if (s < 6'd52) begin
      c = CHAR_LA + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = CHAR_D0 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  // Returns a valid flag in the top bit and the six-bit value below it.
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[CHAR_UA:CHAR_UZ]}) begin
      r = {1'b1, 6'(c - CHAR_UA)};
    end else if (c inside {[CHAR_LA:CHAR_LZ]}) begin
      r = {1'b1, 6'(c - CHAR_LA + 8'd26)};
    end else if (c inside {[CHAR_D0:CHAR_D9]}) begin
      r = {1'b1, 6'(c - CHAR_D0 + 8'd52)};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/base64_codec.sv
// A result item is registered and appears on the output in the cycle after the input item is accepted.
// Throughput: one input item per cycle while each causes at most one result and the receiver
// is ready. An encode item that completes a group loads four results, and no further item is
// taken until the last of them leaves.
// Reset: asynchronous, active low; mode returns to encode and all stream state is cleared.
`timescale 1ns / 1ps
`default_nettype none

module base64_codec import b64_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_req_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  value_o,
  output logic             has_value_o,
  output logic             end_of_stream_o
);

  b64_mode_e   mode_q, mode_d;
  logic        cfg_wr;
  logic        mode_wr;
  logic        fire;
  b64_group_t  group;
  b64_result_t result;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign mode_wr = cfg_wr && (paddr[2] == REG_MODE);
  assign mode_d  = b64_mode_e'(pwdata[0]);
  assign prdata  = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
    end else if (mode_wr) begin
      mode_q <= mode_d;
    end
  end

  assign fire = in_valid_i && in_ready_o;

  b64_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .clear_i (mode_wr),
    .fire_i  (fire),
    .byte_i  (byte_req_i),
    .last_i  (last_i),
    .group_o (group)
  );

  b64_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .group_i     (group),
    .free_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign value_o         = result.value;
  assign has_value_o     = result.has_value;
  assign end_of_stream_o = result.eos;

endmodule

`default_nettype wire

### rtl/b64_core.sv
`timescale 1ns / 1ps
`default_nettype none

module b64_core import b64_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire b64_mode_e  mode_i,
  input  wire logic       clear_i,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output b64_group_t      group_o
);

  logic [15:0] held_bytes_q, held_bytes_d;
  logic [1:0]  held_count_q, held_count_d;
  logic [5:0]  acc_q, acc_d;
  logic [2:0]  bit_count_q, bit_count_d;
  logic        pad_q, pad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bytes_q <= '0;
      held_count_q <= '0;
      acc_q        <= '0;
      bit_count_q  <= '0;
      pad_q        <= 1'b0;
    end else if (clear_i) begin
      held_bytes_q <= '0;
      held_count_q <= '0;
      acc_q        <= '0;
      bit_count_q  <= '0;
      pad_q        <= 1'b0;
    end else if (fire_i) begin
      held_bytes_q <= held_bytes_d;
      held_count_q <= held_count_d;
      acc_q        <= acc_d;
      bit_count_q  <= bit_count_d;
      pad_q        <= pad_d;
    end
  end

  logic [2:0]  count;
  logic [23:0] code;
  logic [6:0]  sx;
  logic [11:0] acc_wide;
  logic [3:0]  cnt_wide;
  logic [3:0]  cnt_rem;
  logic        emit;
  logic [7:0]  dec_byte;
  logic [11:0] mask;
  b64_result_t marker;

  always_comb begin
    held_bytes_d = held_bytes_q;
    held_count_d = held_count_q;
    acc_d        = acc_q;
    bit_count_d  = bit_count_q;
    pad_d        = pad_q;
    group_o      = '0;
    marker       = '{value: 8'h00, has_value: 1'b0, eos: 1'b1};

    count = {1'b0, held_count_q} + 3'd1;
    case (count)
      3'd1:    code = {byte_i, 16'h0000};
      3'd2:    code = {held_bytes_q[7:0], byte_i, 8'h00};
      default: code = {held_bytes_q, byte_i};
    endcase

    sx       = char_to_sextet(byte_i);
    acc_wide = {acc_q, sx[5:0]};
    cnt_wide = {1'b0, bit_count_q} + 4'd6;
    cnt_rem  = cnt_wide - 4'd8;
    emit     = 1'b0;
    dec_byte = 8'(acc_wide >> cnt_rem);
    mask     = '0;

    if (mode_i == MODE_ENCODE) begin
      if (count < 3'd3 && !last_i) begin
        held_bytes_d = {held_bytes_q[7:0], byte_i};
        held_count_d = count[1:0];
      end else begin
        group_o.num    = NUM_W'(GROUP_MAX);
        group_o.res[0] = '{value: sextet_to_char(code[23:18]), has_value: 1'b1, eos: 1'b0};
        group_o.res[1] = '{value: sextet_to_char(code[17:12]), has_value: 1'b1, eos: 1'b0};
        group_o.res[2] = '{value: (count >= 3'd2) ? sextet_to_char(code[11:6]) : CHAR_PAD,
                           has_value: 1'b1, eos: 1'b0};
        group_o.res[3] = '{value: (count == 3'd3) ? sextet_to_char(code[5:0]) : CHAR_PAD,
                           has_value: 1'b1, eos: last_i};
        held_bytes_d = '0;
        held_count_d = '0;
      end
    end else begin
      if (!pad_q) begin
        if (byte_i == CHAR_PAD) begin
          pad_d = 1'b1;
        end else if (sx[6]) begin
          emit        = cnt_wide[3];
          bit_count_d = emit ? cnt_rem[2:0] : cnt_wide[2:0];
          mask        = (12'h001 << bit_count_d) - 12'h001;
          acc_d       = 6'(acc_wide & mask);
        end
      end
      group_o.res[0] = emit ?
                       b64_result_t'{value: dec_byte, has_value: 1'b1, eos: 1'b0} : marker;
      group_o.res[1] = marker;
      group_o.num    = NUM_W'({1'b0, emit} + {1'b0, last_i});
    end

    // The end of a stream clears all stream state in either mode.
    if (last_i) begin
      held_bytes_d = '0;
      held_count_d = '0;
      acc_d        = '0;
      bit_count_d  = '0;
      pad_d        = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/b64_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module b64_outbuf import b64_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire b64_group_t group_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output b64_result_t     result_o
);

  b64_result_t [GROUP_MAX-1:0] res_q;
  logic [NUM_W-1:0]            cnt_q, cnt_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        pop;
  logic                        pop_last;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign pop_last    = pop && ({1'b0, idx_q} == cnt_q - NUM_W'(1));
  // The buffer takes a new group when empty, or in the same cycle as its last item leaves.
  assign free_o      = !out_valid_o || pop_last;
  assign result_o    = res_q[idx_q];

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (pop_last) begin
      cnt_d = '0;
      idx_d = '0;
    end else if (pop) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (load_i && group_i.num != '0) begin
      cnt_d = group_i.num;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && group_i.num != '0) begin
      res_q <= group_i.res;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NUM_W'(GROUP_MAX))
    else $error("result count beyond group size");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, idx_q} < cnt_q))
    else $error("read index beyond stored results");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && out_valid_o) |-> pop_last)
    else $error("group loaded over undelivered results");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_last && !load_i) |=> !out_valid_o)
    else $error("buffer still valid after last item left");

endmodule

`default_nettype wire

### dv/base64_codec_tb.sv
`timescale 1ns / 1ps

module base64_codec_tb;
  import b64_pkg::*;

  localparam int          LIMIT         = 400_000;
  localparam int          SETTLE        = 4;
  localparam int          REG_COUNT     = 1;
  localparam logic [2:0]  ADDR_MODE     = 3'(4 * REG_MODE);
  localparam logic [2:0]  ADDR_UNMAPPED = 3'(4 * REG_COUNT);
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } code_item_t;

  typedef struct {
    bit         wr_mode;
    b64_mode_e  mode;
    logic [7:0] data;
    logic       last;
    bit         typed;
    b64_group_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_req_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  value_o;
  logic        has_value_o;
  logic        end_of_stream_o;

  base64_codec dut (.*);

  // Predictor state, mirrored from the block.
  b64_mode_e    codec_mode = MODE_ENCODE;
  logic [15:0]  pend_bytes = '0;
  int           pend_cnt = 0;
  logic [11:0]  sext_acc = '0;
  int           sext_bits = 0;
  bit           pad_seen = 1'b0;
  logic [6:0]   sextet_lut [256];

  b64_result_t  pending_results[$];
  stim_row_t    rows[$];
  int           errors = 0;
  int           cycles = 0;
  int           ready_hold = 0;
  bit           burst = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("base64_codec_tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    return ALPHABET[8 * (63 - int'(s)) +: 8];
  endfunction

  function automatic b64_result_t mk_res(input logic [7:0] v, input logic hv, input logic eos);
    b64_result_t r;
    r.value     = v;
    r.has_value = hv;
    r.eos       = eos;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  function automatic void clear_stream();
    pend_bytes = '0;
    pend_cnt   = 0;
    sext_acc   = '0;
    sext_bits  = 0;
    pad_seen   = 1'b0;
  endfunction

  // Works out every result that one item causes and advances the mirrored state.
  function automatic b64_group_t predict_item(input logic [7:0] d, input logic l);
    b64_group_t  g;
    int          cnt;
    int          n;
    logic [23:0] grp;
    logic [23:0] code;
    logic [11:0] shifted;
    g = '0;
    n = 0;
    if (codec_mode == MODE_ENCODE) begin
      cnt = pend_cnt + 1;
      grp = {pend_bytes, d};
      if (cnt < 3 && !l) begin
        pend_bytes = grp[15:0];
        pend_cnt   = cnt;
      end else begin
        code = grp << (8 * (3 - cnt));
        g.res[0] = mk_res(b64_char(code[23:18]), 1'b1, 1'b0);
        g.res[1] = mk_res(b64_char(code[17:12]), 1'b1, 1'b0);
        g.res[2] = mk_res(cnt >= 2 ? b64_char(code[11:6]) : CHAR_PAD, 1'b1, 1'b0);
        g.res[3] = mk_res(cnt >= 3 ? b64_char(code[5:0]) : CHAR_PAD, 1'b1, l);
        n = 4;
        clear_stream();
      end
    end else begin
      if (!pad_seen) begin
        if (d == CHAR_PAD) begin
          pad_seen = 1'b1;
        end else if (sextet_lut[d][6]) begin
          sext_acc  = {sext_acc[5:0], sextet_lut[d][5:0]};
          sext_bits = sext_bits + 6;
          if (sext_bits >= 8) begin
            sext_bits = sext_bits - 8;
            shifted   = sext_acc >> sext_bits;
            g.res[n]  = mk_res(shifted[7:0], 1'b1, 1'b0);
            n++;
          end
          sext_acc = sext_acc & ((12'd1 << sext_bits) - 12'd1);
        end
      end
      if (l) begin
        g.res[n] = mk_res(8'h00, 1'b0, 1'b1);
        n++;
        clear_stream();
      end
    end
    g.num = n[NUM_W-1:0];
    return g;
  endfunction

  // Turns a typed string of characters (encode) or bytes (decode) into results.
  function automatic b64_group_t want_from(input string s, input b64_mode_e m, input logic l);
    b64_group_t g;
    int         n;
    g = '0;
    n = s.len();
    for (int i = 0; i < n; i++) begin
      g.res[i] = mk_res(s[i], 1'b1, (m == MODE_ENCODE) && l && (i == n - 1));
    end
    if (m == MODE_DECODE && l) begin
      g.res[n] = mk_res(8'h00, 1'b0, 1'b1);
      n++;
    end
    g.num = n[NUM_W-1:0];
    return g;
  endfunction

  task automatic add_row(input bit wr, input b64_mode_e m, input logic [7:0] d,
                         input logic l, input bit typed, input string want);
    stim_row_t r;
    r.wr_mode = wr;
    r.mode    = m;
    r.data    = d;
    r.last    = l;
    r.typed   = typed;
    r.want    = typed ? want_from(want, m, l) : '0;
    rows.push_back(r);
  endtask

  // Receiver: runs of ready, short stalls and now and then a long one.
  always @(posedge clk_i) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 20);
      end else if (r < 95) begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    b64_result_t got;
    b64_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = mk_res(value_o, has_value_o, end_of_stream_o);
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: value %02h has_value %0b eos %0b",
                             got.value, got.has_value, got.eos));
      end else begin
        exp_res = pending_results.pop_front();
        if (got.value !== exp_res.value || got.has_value !== exp_res.has_value ||
            got.eos !== exp_res.eos) begin
          flag_error($sformatf(
            "result mismatch: expected value %02h has_value %0b eos %0b, got %02h %0b %0b",
            exp_res.value, exp_res.has_value, exp_res.eos,
            got.value, got.has_value, got.eos));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic pause_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_item(input logic [7:0] d, input logic l, input bit typed,
                           input b64_group_t want);
    b64_group_t g;
    in_valid_i <= 1'b1;
    byte_req_i <= d;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    g = predict_item(d, l);
    if (typed) g = want;
    for (int k = 0; k < int'(g.num); k++) pending_results.push_back(g.res[k]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic apb_access(input logic [2:0] a, input logic w, input logic [31:0] wd,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= w;
    paddr   <= a;
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes the mode once the block has gone quiet, then reads it back. A write
  // beyond the last register must leave the mode alone.
  task automatic set_mode(input b64_mode_e m);
    logic [31:0] rd;
    drain();
    repeat (SETTLE) @(posedge clk_i);
    apb_access(ADDR_MODE, 1'b1, {31'($urandom()), m}, rd);
    codec_mode = m;
    clear_stream();
    apb_access(ADDR_UNMAPPED, 1'b1, {31'($urandom()), ~m}, rd);
    apb_access(ADDR_MODE, 1'b0, '0, rd);
    if (rd !== 32'(codec_mode)) begin
      flag_error($sformatf("mode readback: expected %08h, got %08h", 32'(codec_mode), rd));
    end
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (sextet_lut[c][6] || c == CHAR_PAD);
    return c;
  endfunction

  task automatic run_phase(input b64_mode_e m, input int n_items);
    code_item_t stream[$];
    int         sent;
    int         len;
    int         groups;
    int         tail;
    int         r;
    logic [7:0] d;
    sent = 0;
    set_mode(m);
    while (sent < n_items) begin
      stream.delete();
      if (m == MODE_ENCODE) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          d = (r < 10) ? 8'hFF : (r < 20) ? 8'h00 : 8'($urandom_range(0, 255));
          stream.push_back('{data: d, last: 1'b0});
        end
      end else if ($urandom_range(0, 9) < 7) begin
        // Well-formed text: whole quads, then optionally a padded tail of two or three characters.
        groups = $urandom_range(0, 3);
        tail   = $urandom_range(0, 2);
        len    = groups * 4 + ((tail == 0) ? 0 : tail + 1);
        if (len == 0) len = 1;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 14) == 0) stream.push_back('{data: noise_char(), last: 1'b0});
          stream.push_back('{data: b64_char(6'($urandom_range(0, 63))), last: 1'b0});
        end
        for (int i = tail; i > 0 && i < 3; i++) stream.push_back('{data: CHAR_PAD, last: 1'b0});
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          d = ($urandom_range(0, 11) == 0) ? CHAR_PAD : 8'($urandom_range(0, 255));
          stream.push_back('{data: d, last: 1'b0});
        end
      end
      stream[stream.size() - 1].last = 1'b1;
      burst = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < stream.size() && sent < n_items; i++) begin
        send_item(stream[i].data, stream[i].last, 1'b0, '0);
        sent++;
        pause_sender();
      end
      burst = 1'b0;
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    b64_mode_e phase_modes[5];
    int        phase_items[5];
    for (int i = 0; i < 256; i++) sextet_lut[i] = '0;
    for (int i = 0; i < 64; i++) sextet_lut[b64_char(6'(i))] = {1'b1, 6'(i)};

    // Directed items; the mode after reset is encode.
    add_row(0, MODE_ENCODE, 8'h00, 1, 1, "AA==");
    add_row(0, MODE_ENCODE, 8'hFF, 0, 1, "");
    add_row(0, MODE_ENCODE, 8'hFF, 1, 1, "//8=");
    add_row(0, MODE_ENCODE, "M",   0, 1, "");
    add_row(0, MODE_ENCODE, "a",   0, 1, "");
    add_row(0, MODE_ENCODE, "n",   0, 1, "TWFu");
    add_row(0, MODE_ENCODE, 8'hFB, 0, 1, "");
    add_row(0, MODE_ENCODE, 8'hEF, 0, 1, "");
    add_row(0, MODE_ENCODE, 8'hBE, 1, 1, "++++");
    // A partial group that the mode write below throws away.
    add_row(0, MODE_ENCODE, 8'h12, 0, 0, "");
    add_row(1, MODE_DECODE, "T",   0, 1, "");
    add_row(0, MODE_DECODE, "W",   0, 1, "M");
    add_row(0, MODE_DECODE, "F",   0, 1, "a");
    add_row(0, MODE_DECODE, "u",   0, 1, "n");
    add_row(0, MODE_DECODE, 8'h0A, 0, 1, "");
    add_row(0, MODE_DECODE, 8'hFF, 0, 1, "");
    add_row(0, MODE_DECODE, "Q",   0, 1, "");
    add_row(0, MODE_DECODE, "=",   0, 1, "");
    add_row(0, MODE_DECODE, "A",   0, 1, "");
    add_row(0, MODE_DECODE, "B",   1, 1, "");
    add_row(0, MODE_DECODE, "=",   1, 1, "");
    add_row(0, MODE_DECODE, "/",   0, 1, "");
    add_row(0, MODE_DECODE, "+",   1, 1, "\377");
    add_row(1, MODE_ENCODE, "A",   1, 0, "");

    phase_modes = '{MODE_DECODE, MODE_ENCODE, MODE_ENCODE, MODE_DECODE, MODE_ENCODE};
    phase_items = '{120, 100, 40, 120, 40};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].wr_mode) set_mode(rows[i].mode);
      send_item(rows[i].data, rows[i].last, rows[i].typed, rows[i].want);
      pause_sender();
    end

    foreach (phase_modes[p]) run_phase(phase_modes[p], phase_items[p]);

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("base64_codec_tb passed");
    end else begin
      $display("base64_codec_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/b64_pkg.sv
rtl/b64_core.sv
rtl/b64_outbuf.sv
rtl/base64_codec.sv
dv/base64_codec_tb.sv
